### hdl/spf_pkg.sv
// Shared constants, payload types and register codes of the spectrum peak finder.
package spf_pkg;

  localparam int unsigned MAX_SAMPLES = 2048;
  localparam int unsigned MAX_PEAKS   = 32;
  localparam int unsigned RESULT_CAP  = 32;
  localparam int unsigned PEAK_CAP    = (MAX_PEAKS < RESULT_CAP) ? MAX_PEAKS : RESULT_CAP;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned WIN_W         = 8;
  localparam int unsigned PEAK_INDEX_W  = 11;
  localparam int unsigned PEAK_NUMBER_W = 5;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SCAN_W = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 2;
  localparam int unsigned PA_W   = $clog2(PEAK_CAP);
  localparam int unsigned PC_W   = $clog2(PEAK_CAP + 1);

  localparam logic [SAMPLE_W-1:0] MAIN_THR_RESET = 16'd1000;
  localparam logic [SAMPLE_W-1:0] SIDE_THR_RESET = 16'd1000;
  localparam logic [WIN_W-1:0]    WINDOW_RESET   = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAIN_THR = 2'd0,
    CFG_SIDE_THR = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_word_t;

  typedef struct packed {
    logic [PEAK_INDEX_W-1:0]  peak_index;
    logic [SAMPLE_W-1:0]      peak_value;
    logic [PEAK_NUMBER_W-1:0] peak_number;
    logic                     last_peak;
    logic                     none_found;
    logic                     overflow;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [SAMPLE_W-1:0] value;
  } peak_entry_t;

endpackage

### hdl/spf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/spectrum_peak_finder_core.sv
// Top level of the spectrum peak finder: sequencer, shared run unit and stores.
//
// Use: a spectrum is written as a sequence of sample words on the input channel, one
// word a cycle, the final one marked by last_sample. The forward peak pass runs while
// the samples load. After the last word the input stalls. Two outer scans then reread
// the sample RAM through the same run unit, each visited sample taking a registered
// RAM read, then a compare and update. Results follow in ascending index order, each
// through a peak RAM read, load and hold.
// A stall holds the result in the output register and the sequencer waits; the input
// reopens the cycle after the final result word is taken.
// Configuration writes are always ready and take effect at once; they are meant for
// idle periods between spectra. Index 0 is the main threshold, 1 the side threshold
// and 2 the window length; other indexes are ignored.
// Reset restores the register defaults and clears the sample and peak counts and
// the run state. The sample and peak RAMs need no clearing, as only entries written
// for the current spectrum are ever read.
module spectrum_peak_finder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  spf_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output spf_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spf_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [spf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  typedef enum logic [9:0] {
    ST_LOAD      = 10'b00_0000_0001,
    ST_PEND      = 10'b00_0000_0010,
    ST_BSET      = 10'b00_0000_0100,
    ST_SCAN_RD   = 10'b00_0000_1000,
    ST_SCAN_EV   = 10'b00_0001_0000,
    ST_SCAN_END  = 10'b00_0010_0000,
    ST_FSET      = 10'b00_0100_0000,
    ST_EMIT_RD   = 10'b00_1000_0000,
    ST_EMIT_LD   = 10'b01_0000_0000,
    ST_EMIT_HOLD = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [spf_pkg::SAMPLE_W-1:0] main_thr_q, side_thr_q;
  logic [spf_pkg::WIN_W-1:0]    win_len_q;

  logic [spf_pkg::CNT_W-1:0]    sample_count_q, sample_count_d;
  logic [spf_pkg::PC_W-1:0]     peak_count_q, peak_count_d;
  logic [spf_pkg::PC_W-1:0]     nc_q, nc_d, nb_q, nb_d;
  logic                         run_active_q, run_active_d;
  logic [spf_pkg::SAMPLE_W-1:0] run_max_val_q, run_max_val_d;
  logic [spf_pkg::IDX_W-1:0]    run_max_idx_q, run_max_idx_d;
  logic [spf_pkg::WIN_W-1:0]    miss_q, miss_d, miss_inc;
  logic                         overflow_q, overflow_d;
  logic                         out_valid_q, out_valid_d;

  logic [spf_pkg::IDX_W-1:0]         first_idx_q, first_idx_d, lastf_idx_q, lastf_idx_d;
  logic signed [spf_pkg::SCAN_W-1:0] scan_idx_q, scan_idx_d;
  logic                              backward_q, backward_d;
  logic [spf_pkg::PA_W-1:0]          emit_k_q, emit_k_d;
  spf_pkg::out_word_t                out_word_q, out_word_d;

  logic in_accept, out_accept, scan_go, fwd_pass;

  // Shared run unit.
  logic                         u_en;
  logic [spf_pkg::SAMPLE_W-1:0] u_sample, u_thr;
  logic [spf_pkg::IDX_W-1:0]    u_index;
  logic                         keep_req;

  // Stores.
  logic                         s_we;
  logic [spf_pkg::IDX_W-1:0]    s_waddr, s_raddr;
  logic [spf_pkg::SAMPLE_W-1:0] s_rdata;
  logic                         p_we;
  logic [spf_pkg::PA_W-1:0]     p_waddr, p_raddr;
  spf_pkg::peak_entry_t         p_wdata, p_rdata;
  logic [spf_pkg::PC_W-1:0]     emit_kk, emit_addr;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_accept  = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign fwd_pass    = (state_q == ST_LOAD) || (state_q == ST_PEND);

  assign scan_go = backward_q
      ? (scan_idx_q >= $signed(spf_pkg::SCAN_W'(1)))
      : (scan_idx_q < $signed(spf_pkg::SCAN_W'(sample_count_q)));

  // Result order: backward-scan peaks reversed, then forward-pass peaks, then the
  // forward-scan peaks, which already sit in that order in the peak RAM.
  always_comb begin
    emit_kk = spf_pkg::PC_W'(emit_k_q);
    if (emit_kk < nb_q) begin
      emit_addr = nc_q + nb_q - spf_pkg::PC_W'(1) - emit_kk;
    end else if (emit_kk < nc_q + nb_q) begin
      emit_addr = emit_kk - nb_q;
    end else begin
      emit_addr = emit_kk;
    end
  end

  always_comb begin
    state_d        = state_q;
    sample_count_d = sample_count_q;
    peak_count_d   = peak_count_q;
    nc_d           = nc_q;
    nb_d           = nb_q;
    run_active_d   = run_active_q;
    run_max_val_d  = run_max_val_q;
    run_max_idx_d  = run_max_idx_q;
    miss_d         = miss_q;
    miss_inc       = miss_q + spf_pkg::WIN_W'(1);
    overflow_d     = overflow_q;
    out_valid_d    = out_valid_q;
    first_idx_d    = first_idx_q;
    lastf_idx_d    = lastf_idx_q;
    scan_idx_d     = scan_idx_q;
    backward_d     = backward_q;
    emit_k_d       = emit_k_q;
    out_word_d     = out_word_q;
    u_en           = 1'b0;
    u_sample       = '0;
    u_thr          = '0;
    u_index        = '0;
    keep_req       = 1'b0;
    s_we           = 1'b0;
    s_waddr        = sample_count_q[spf_pkg::IDX_W-1:0];
    s_raddr        = scan_idx_q[spf_pkg::IDX_W-1:0];
    p_we           = 1'b0;
    p_waddr        = peak_count_q[spf_pkg::PA_W-1:0];
    p_wdata.index  = run_max_idx_q;
    p_wdata.value  = run_max_val_q;
    p_raddr        = emit_addr[spf_pkg::PA_W-1:0];

    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (sample_count_q < spf_pkg::CNT_W'(spf_pkg::MAX_SAMPLES)) begin
            s_we           = 1'b1;
            sample_count_d = sample_count_q + spf_pkg::CNT_W'(1);
            u_en           = 1'b1;
            u_sample       = in_word_i.sample;
            u_thr          = main_thr_q;
            u_index        = sample_count_q[spf_pkg::IDX_W-1:0];
          end else begin
            overflow_d = 1'b1;
          end
          if (in_word_i.last_sample) begin
            state_d = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        // A run still open at the end counts, unless its maximum is the first sample.
        keep_req     = run_active_q && (run_max_idx_q != '0);
        run_active_d = 1'b0;
        miss_d       = '0;
        state_d      = ST_BSET;
      end
      ST_BSET: begin
        nc_d = peak_count_q;
        if (peak_count_q == '0) begin
          out_word_d.peak_index  = '0;
          out_word_d.peak_value  = '0;
          out_word_d.peak_number = '0;
          out_word_d.last_peak   = 1'b1;
          out_word_d.none_found  = 1'b1;
          out_word_d.overflow    = overflow_q;
          out_valid_d            = 1'b1;
          state_d                = ST_EMIT_HOLD;
        end else begin
          scan_idx_d = spf_pkg::SCAN_W'(first_idx_q) - spf_pkg::SCAN_W'(win_len_q);
          backward_d = 1'b1;
          state_d    = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = scan_go ? ST_SCAN_EV : ST_SCAN_END;
      end
      ST_SCAN_EV: begin
        u_en       = 1'b1;
        u_sample   = s_rdata;
        u_thr      = side_thr_q;
        u_index    = scan_idx_q[spf_pkg::IDX_W-1:0];
        scan_idx_d = backward_q ? (scan_idx_q - spf_pkg::SCAN_W'(1))
                                : (scan_idx_q + spf_pkg::SCAN_W'(1));
        state_d    = ST_SCAN_RD;
      end
      ST_SCAN_END: begin
        keep_req     = run_active_q && (run_max_idx_q != '0);
        run_active_d = 1'b0;
        miss_d       = '0;
        emit_k_d     = '0;
        state_d      = backward_q ? ST_FSET : ST_EMIT_RD;
      end
      ST_FSET: begin
        nb_d       = peak_count_q - nc_q;
        scan_idx_d = spf_pkg::SCAN_W'(lastf_idx_q) + spf_pkg::SCAN_W'(win_len_q);
        backward_d = 1'b0;
        state_d    = ST_SCAN_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_word_d.peak_index  = spf_pkg::PEAK_INDEX_W'(p_rdata.index);
        out_word_d.peak_value  = p_rdata.value;
        out_word_d.peak_number = spf_pkg::PEAK_NUMBER_W'(emit_k_q);
        out_word_d.last_peak   = (emit_kk + spf_pkg::PC_W'(1)) == peak_count_q;
        out_word_d.none_found  = 1'b0;
        out_word_d.overflow    = overflow_q;
        out_valid_d            = 1'b1;
        state_d                = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_accept) begin
          out_valid_d = 1'b0;
          if (out_word_q.last_peak) begin
            sample_count_d = '0;
            peak_count_d   = '0;
            nc_d           = '0;
            nb_d           = '0;
            run_active_d   = 1'b0;
            run_max_val_d  = '0;
            run_max_idx_d  = '0;
            miss_d         = '0;
            overflow_d     = 1'b0;
            state_d        = ST_LOAD;
          end else begin
            emit_k_d = emit_k_q + spf_pkg::PA_W'(1);
            state_d  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // Run update: start at the threshold, follow an equal or greater sample, and
    // close the run once the miss count reaches the window length.
    if (u_en) begin
      if (!run_active_q) begin
        if (u_sample >= u_thr) begin
          run_active_d  = 1'b1;
          run_max_idx_d = u_index;
          run_max_val_d = u_sample;
          miss_d        = '0;
        end
      end else if (u_sample >= run_max_val_q) begin
        run_max_idx_d = u_index;
        run_max_val_d = u_sample;
        miss_d        = '0;
      end else if (miss_inc >= win_len_q) begin
        keep_req     = 1'b1;
        run_active_d = 1'b0;
        miss_d       = '0;
      end else begin
        miss_d = miss_inc;
      end
    end

    if (keep_req) begin
      if (peak_count_q < spf_pkg::PC_W'(spf_pkg::PEAK_CAP)) begin
        p_we         = 1'b1;
        peak_count_d = peak_count_q + spf_pkg::PC_W'(1);
        if (peak_count_q == '0) begin
          first_idx_d = run_max_idx_q;
        end
        if (fwd_pass) begin
          lastf_idx_d = run_max_idx_q;
        end
      end else begin
        overflow_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      sample_count_q <= '0;
      peak_count_q   <= '0;
      nc_q           <= '0;
      nb_q           <= '0;
      run_active_q   <= 1'b0;
      run_max_val_q  <= '0;
      run_max_idx_q  <= '0;
      miss_q         <= '0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      sample_count_q <= sample_count_d;
      peak_count_q   <= peak_count_d;
      nc_q           <= nc_d;
      nb_q           <= nb_d;
      run_active_q   <= run_active_d;
      run_max_val_q  <= run_max_val_d;
      run_max_idx_q  <= run_max_idx_d;
      miss_q         <= miss_d;
      overflow_q     <= overflow_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_idx_q <= first_idx_d;
    lastf_idx_q <= lastf_idx_d;
    scan_idx_q  <= scan_idx_d;
    backward_q  <= backward_d;
    emit_k_q    <= emit_k_d;
    out_word_q  <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_thr_q <= spf_pkg::MAIN_THR_RESET;
      side_thr_q <= spf_pkg::SIDE_THR_RESET;
      win_len_q  <= spf_pkg::WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spf_pkg::CFG_MAIN_THR: main_thr_q <= cfg_data_i;
        spf_pkg::CFG_SIDE_THR: side_thr_q <= cfg_data_i;
        spf_pkg::CFG_WINDOW:   win_len_q  <= spf_pkg::WIN_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  spf_ram #(
    .WIDTH (spf_pkg::SAMPLE_W),
    .DEPTH (spf_pkg::MAX_SAMPLES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (in_word_i.sample),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  spf_ram #(
    .WIDTH ($bits(spf_pkg::peak_entry_t)),
    .DEPTH (spf_pkg::PEAK_CAP)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result word is pending");

  a_peak_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_count_q <= spf_pkg::PC_W'(spf_pkg::PEAK_CAP))
    else $error("peak count beyond capacity");

  a_sample_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_count_q <= spf_pkg::CNT_W'(spf_pkg::MAX_SAMPLES))
    else $error("sample count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_EV) |->
      (scan_idx_q >= $signed(spf_pkg::SCAN_W'(0)) &&
       scan_idx_q < $signed(spf_pkg::SCAN_W'(sample_count_q))))
    else $error("outer scan reads outside the stored spectrum");

  a_clean_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_word_o.last_peak) |=>
      (!in_stall_o && peak_count_q == '0 && sample_count_q == '0 && !overflow_q))
    else $error("spectrum state not cleared after the final result");
`endif

endmodule
